// ===== rtl/pdc_pkg.sv =====
// Shared types, constants and codes of the Porter-Duff pixel compositor.
package pdc_pkg;

    localparam int PIXEL_DEPTH_DEF = 16384;
    localparam int BAND_COUNT_DEF  = 32;

    localparam logic [7:0] WIDTH_RESET  = 8'd160;
    localparam logic [7:0] HEIGHT_RESET = 8'd80;

    localparam logic [4:0] RB_MAX = 5'd31;
    localparam logic [5:0] G_MAX  = 6'd63;
    localparam logic [7:0] A_MAX  = 8'd255;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        BM_OVER  = 3'd0,
        BM_IN    = 3'd1,
        BM_OUT   = 3'd2,
        BM_ATOP  = 3'd3,
        BM_XOR   = 3'd4,
        BM_PLUS  = 3'd5
    } t_blend_mode;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WEIGHT,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [15:0]        src_colour;
        logic [7:0]         src_alpha;
        logic [2:0]         blend_mode;
    } t_in_item;

    typedef struct packed {
        logic        visible;
        logic        changed;
        logic [15:0] result_colour;
        logic [7:0]  result_alpha;
        logic [31:0] band_dirty_bits;
    } t_out_item;

endpackage

// ===== rtl/pdc_in_if.sv =====
// Input channel of the compositor: valid/ready with one pixel action.
interface pdc_in_if import pdc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pdc_out_if.sv =====
// Result channel of the compositor: valid/ready with one result item.
interface pdc_out_if import pdc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pdc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module pdc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/porter_duff_pixel_compositor.sv =====
// Top level of the Porter-Duff pixel compositor over an RGB565 + alpha store.
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+-------------------------------------
//  i_in     | in        | valid/ready   | action, x/y, source colour/alpha, mode
//  o_out    | out       | valid/ready   | visible, changed, pixel, band dirty word
//  i_cfg_*  | in        | write enable  | surface width (0), surface height (1)
//
// Each item passes through address multiply, pixel RAM read, weight multiply,
// channel multiply, then write back and result load.
// Reset is synchronous and clears the FSM, the dirty mask and the result valid.
// The pixel RAM is not cleared. A new item is taken while a result waits;
// the write back waits in its last step until the result register frees up.
module porter_duff_pixel_compositor import pdc_pkg::*; #(
    parameter int PIXEL_DEPTH = PIXEL_DEPTH_DEF,
    parameter int BAND_COUNT  = BAND_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdc_in_if.sink     i_in,
    pdc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    localparam int AW = $clog2(PIXEL_DEPTH);
    localparam int BW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    t_state r_state, n_state;

    logic [7:0] r_width, r_height;

    // item registers
    t_action     r_action;
    t_blend_mode r_mode;
    logic        r_mode_ok;
    logic [15:0] r_sc;
    logic [7:0]  r_sa;
    logic [7:0]  r_x8, r_y8;
    logic        r_clip_ok;
    logic [16:0] r_idx;
    logic        r_vis;
    logic [15:0] r_dc;
    logic [7:0]  r_da;
    logic [15:0] r_wa, r_wb;
    logic [20:0] r_pa_r, r_pb_r, r_pa_b, r_pb_b;
    logic [21:0] r_pa_g, r_pb_g;
    logic [16:0] r_asum;

    logic [31:0] r_dirty [BAND_COUNT];

    logic      r_out_valid;
    t_out_item r_out_data;

    // control
    logic w_in_ready, w_ram_re, w_finish, w_accept;

    // datapath
    logic        w_x_ok, w_y_ok;
    logic [15:0] w_prod;
    logic [16:0] w_idx;
    logic [23:0] w_rdata;
    logic [7:0]  w_fa, w_fb;
    logic        w_mode_ok;
    logic [21:0] w_sum_r, w_sum_b;
    logic [22:0] w_sum_g;
    logic [4:0]  w_r, w_b;
    logic [5:0]  w_g;
    logic [7:0]  w_a;
    logic [15:0] w_oc;
    logic        w_chg;
    logic        w_band_ok;
    logic [31:0] w_band_word;
    logic [31:0] w_bit;
    logic        w_set_dirty;
    logic        w_ram_we;
    logic [23:0] w_wdata;
    t_out_item   w_res;

    assign w_accept = i_in.valid && w_in_ready;

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_READ;
            ST_READ:   n_state = ST_WEIGHT;
            ST_WEIGHT: n_state = ST_MIX;
            ST_MIX:    n_state = ST_DONE;
            ST_DONE:   if (w_finish) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_ram_re   = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_READ: w_ram_re   = 1'b1;
            ST_DONE: w_finish   = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- capture and clip ----------------
    assign w_x_ok = !i_in.data.x_coord[15] && (i_in.data.x_coord[14:8] == 7'd0)
                    && (i_in.data.x_coord[7:0] < r_width);
    assign w_y_ok = !i_in.data.y_coord[15] && (i_in.data.y_coord[14:8] == 7'd0)
                    && (i_in.data.y_coord[7:0] < r_height);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= t_action'(i_in.data.action);
            r_mode    <= t_blend_mode'(i_in.data.blend_mode);
            r_sc      <= i_in.data.src_colour;
            r_sa      <= i_in.data.src_alpha;
            r_x8      <= i_in.data.x_coord[7:0];
            r_y8      <= i_in.data.y_coord[7:0];
            r_clip_ok <= w_x_ok && w_y_ok;
        end
    end

    // ---------------- address ----------------
    assign w_prod = r_y8 * r_width;
    assign w_idx  = {1'b0, w_prod} + {9'd0, r_x8};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR) begin
            r_idx <= w_idx;
        end
        if (r_state == ST_READ) begin
            r_vis <= r_clip_ok && (r_idx < 17'(PIXEL_DEPTH));
        end
    end

    // colour in the upper 16 bits, alpha in the lower 8
    pdc_ram #(
        .WIDTH (24),
        .DEPTH (PIXEL_DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // ---------------- Porter-Duff weights ----------------
    always_comb begin
        w_fa      = 8'd0;
        w_fb      = 8'd0;
        w_mode_ok = 1'b1;
        case (r_mode)
            BM_OVER: begin w_fa = A_MAX;             w_fb = A_MAX - r_sa; end
            BM_IN:   begin w_fa = w_rdata[7:0];      w_fb = 8'd0;         end
            BM_OUT:  begin w_fa = A_MAX - w_rdata[7:0]; w_fb = 8'd0;      end
            BM_ATOP: begin w_fa = w_rdata[7:0];      w_fb = A_MAX - r_sa; end
            BM_XOR:  begin w_fa = A_MAX - w_rdata[7:0]; w_fb = A_MAX - r_sa; end
            BM_PLUS: begin w_fa = A_MAX;             w_fb = A_MAX;        end
            default: w_mode_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WEIGHT) begin
            r_dc      <= w_rdata[23:8];
            r_da      <= w_rdata[7:0];
            r_wa      <= r_sa * w_fa;
            r_wb      <= w_rdata[7:0] * w_fb;
            r_mode_ok <= w_mode_ok;
        end
    end

    // ---------------- channel products ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MIX) begin
            r_pa_r <= 21'(r_wa * r_sc[15:11]);
            r_pb_r <= 21'(r_wb * r_dc[15:11]);
            r_pa_g <= 22'(r_wa * r_sc[10:5]);
            r_pb_g <= 22'(r_wb * r_dc[10:5]);
            r_pa_b <= 21'(r_wa * r_sc[4:0]);
            r_pb_b <= 21'(r_wb * r_dc[4:0]);
            r_asum <= {1'b0, r_wa} + {1'b0, r_wb};
        end
    end

    // ---------------- sum, saturate, compare ----------------
    assign w_sum_r = {1'b0, r_pa_r} + {1'b0, r_pb_r};
    assign w_sum_g = {1'b0, r_pa_g} + {1'b0, r_pb_g};
    assign w_sum_b = {1'b0, r_pa_b} + {1'b0, r_pb_b};

    assign w_r  = (w_sum_r[21:16] > 6'(RB_MAX)) ? RB_MAX : w_sum_r[20:16];
    assign w_g  = (w_sum_g[22:16] > 7'(G_MAX))  ? G_MAX  : w_sum_g[21:16];
    assign w_b  = (w_sum_b[21:16] > 6'(RB_MAX)) ? RB_MAX : w_sum_b[20:16];
    assign w_a  = (r_asum[16:8] > 9'(A_MAX))    ? A_MAX  : r_asum[15:8];
    assign w_oc = {w_r, w_g, w_b};

    assign w_chg = (r_action == ACT_DRAW) && r_vis && r_mode_ok
                   && ((w_oc != r_dc) || (w_a != r_da));

    assign w_band_ok   = {1'b0, r_y8[7:3]} < 6'(BAND_COUNT);
    assign w_bit       = 32'd1 << r_x8[7:3];
    assign w_band_word = w_band_ok ? r_dirty[r_y8[BW+2:3]] : 32'd0;
    assign w_set_dirty = w_finish && w_chg && w_band_ok;

    assign w_ram_we = w_finish && r_vis && (w_chg || (r_action == ACT_STORE));
    assign w_wdata  = (r_action == ACT_STORE) ? {r_sc, r_sa} : {w_oc, w_a};

    always_comb begin
        w_res = '0;
        case (r_action)
            ACT_DRAW: begin
                if (r_vis) begin
                    w_res.visible         = 1'b1;
                    w_res.changed         = w_chg;
                    w_res.result_colour   = w_chg ? w_oc : r_dc;
                    w_res.result_alpha    = w_chg ? w_a : r_da;
                    w_res.band_dirty_bits = w_band_word | (w_set_dirty ? w_bit : 32'd0);
                end
            end
            ACT_STORE: begin
                if (r_vis) begin
                    w_res.visible         = 1'b1;
                    w_res.result_colour   = r_sc;
                    w_res.result_alpha    = r_sa;
                    w_res.band_dirty_bits = w_band_word;
                end
            end
            default: ;
        endcase
    end

    // ---------------- dirty mask ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                r_dirty[i] <= 32'd0;
            end
        end else if (w_finish && (r_action == ACT_CLEAR)) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                r_dirty[i] <= 32'd0;
            end
        end else if (w_set_dirty) begin
            r_dirty[r_y8[BW+2:3]] <= r_dirty[r_y8[BW+2:3]] | w_bit;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= w_res;
        end
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_ADDR))
        else $error("accepted item did not start the address step");

    a_write_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_vis && r_state == ST_DONE))
        else $error("pixel write outside a visible write back");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.visible) |->
        (!o_out.data.changed && o_out.data.result_colour == 16'd0
         && o_out.data.result_alpha == 8'd0 && o_out.data.band_dirty_bits == 32'd0))
        else $error("result for a hidden pixel carries data");

    a_clear_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && r_action == ACT_CLEAR) |=> (r_dirty[0] == 32'd0))
        else $error("dirty mask not cleared");

    a_dirty_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_set_dirty |=> ((r_out_data.band_dirty_bits & $past(w_bit)) != 32'd0))
        else $error("changed pixel not marked in its band");
endmodule
